// File: rtl/core/radix_alphabet_int_formatter_assert.svh
// assertion macros for the radix formatter
`ifndef RADIX_ALPHABET_INT_FORMATTER_ASSERT_SVH
`define RADIX_ALPHABET_INT_FORMATTER_ASSERT_SVH
`ifndef SYNTHESIS
`define RAF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RAF_ASSERT_NR(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RAF_ASSERT(lbl, clk, rst_n, prop, msg)
`define RAF_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/core/rafmt_pkg.sv
// shared types, constants and helpers for the radix formatter
`default_nettype none
package rafmt_pkg;
	localparam int DATA_W        = 32;
	localparam int RADIX_W       = 5;
	localparam int ALPHA_W       = 64;
	localparam int SYM_W         = 8;
	localparam int SYM_IDX_W     = 4;
	localparam int MAX_DIGITS    = 32;
	localparam int CNT_W         = 6;
	localparam int PTR_W         = 5;
	localparam int DIV_BITS      = 8;
	localparam int CFG_IDX_W     = 2;
	localparam int MAX_RADIX_DEF = 16;

	localparam logic [RADIX_W-1:0] RADIX_RESET    = 5'd10;
	localparam logic [ALPHA_W-1:0] ALPHA_LO_RESET = 64'h3736353433323130;
	localparam logic [ALPHA_W-1:0] ALPHA_HI_RESET = 64'h4645444342413938;
	localparam logic [SYM_W-1:0]   SYM_PLUS       = 8'h2B;
	localparam logic [SYM_W-1:0]   SYM_MINUS      = 8'h2D;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIX    = 2'd0,
		REG_ALPHA_LO = 2'd1,
		REG_ALPHA_HI = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_SIGN,
		ST_EMIT
	} state_t;

	function automatic logic [SYM_W-1:0] symbol_of(
		input logic [ALPHA_W-1:0]   lo,
		input logic [ALPHA_W-1:0]   hi,
		input logic [SYM_IDX_W-1:0] d
	);
		logic [ALPHA_W-1:0] word;
		word = d[SYM_IDX_W-1] ? hi : lo;
		return word[d[SYM_IDX_W-2:0]*SYM_W +: SYM_W];
	endfunction
endpackage
`default_nettype wire

// File: rtl/core/rafmt_value_if.sv
// input channel: one signed integer per beat
`default_nettype none
interface rafmt_value_if;
	logic                                valid;
	logic                                ready;
	logic signed [rafmt_pkg::DATA_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface
`default_nettype wire

// File: rtl/core/rafmt_symbol_if.sv
// output channel: one character per beat
`default_nettype none
interface rafmt_symbol_if;
	logic                         valid;
	logic                         ready;
	logic [rafmt_pkg::SYM_W-1:0]  symbol;
	logic                         last;

	modport source (output valid, output symbol, output last, input ready);
	modport sink (input valid, input symbol, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/radix_alphabet_int_formatter.sv
// top level: signed integer to text in a configured radix and alphabet
//
//  channel    dir   payload            handshake
//  value_ch   sink  value[31:0] s      valid/ready
//  symbol_ch  src   symbol[7:0], last  valid/ready
//  cfg        in    cfg_index, cfg_data write enable, no stall
//
// one item: accept, an alphabet check of each used symbol in turn, then each digit from the
// shared divider (8 quotient bits a cycle), then one output character per cycle unless stalled
// an invalid radix or alphabet ends the item after the check with no characters
// output register holds a character while symbol_ch stalls; next item accepted once the last is loaded
// reset puts the registers at radix 10 and alphabet 0-9A-F
`default_nettype none
`include "radix_alphabet_int_formatter_assert.svh"
module radix_alphabet_int_formatter #(
	parameter int MAX_RADIX = rafmt_pkg::MAX_RADIX_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [rafmt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rafmt_pkg::ALPHA_W-1:0]     cfg_data,
	rafmt_value_if.sink                            value_ch,
	rafmt_symbol_if.source                         symbol_ch
);
	localparam int DIG_W = $clog2(MAX_RADIX);

	logic [rafmt_pkg::RADIX_W-1:0] radix_q;
	logic [rafmt_pkg::ALPHA_W-1:0] alpha_lo_q;
	logic [rafmt_pkg::ALPHA_W-1:0] alpha_hi_q;

	rafmt_pkg::state_t state_q, state_d;

	logic [DIG_W-1:0]              i_q;
	logic [rafmt_pkg::CNT_W-1:0]   nd_q;
	logic                          neg_q;
	logic [rafmt_pkg::DATA_W-1:0]  mag_q;
	logic [DIG_W-1:0]              digits_q [rafmt_pkg::MAX_DIGITS];

	logic                          out_valid_q;
	logic [rafmt_pkg::SYM_W-1:0]   symbol_q;
	logic                          last_q;

	logic                          accept;
	logic                          slot_free;
	logic                          bad;
	logic                          last_i;
	logic                          stop;
	logic [rafmt_pkg::SYM_W-1:0]   chk_sym;
	logic [rafmt_pkg::CNT_W-1:0]   rd_idx;

	logic                          div_start;
	logic                          div_done;
	logic [rafmt_pkg::DATA_W-1:0]  div_dividend;
	logic [rafmt_pkg::DATA_W-1:0]  div_quot;
	logic [DIG_W-1:0]              div_rem;

	logic                          ready_d;
	logic                          out_load;
	logic [rafmt_pkg::SYM_W-1:0]   sym_d;
	logic                          last_d;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q    <= rafmt_pkg::RADIX_RESET;
			alpha_lo_q <= rafmt_pkg::ALPHA_LO_RESET;
			alpha_hi_q <= rafmt_pkg::ALPHA_HI_RESET;
		end else if (cfg_we) begin
			unique case (rafmt_pkg::cfg_reg_t'(cfg_index))
				rafmt_pkg::REG_RADIX:    radix_q    <= cfg_data[rafmt_pkg::RADIX_W-1:0];
				rafmt_pkg::REG_ALPHA_LO: alpha_lo_q <= cfg_data;
				rafmt_pkg::REG_ALPHA_HI: alpha_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign accept    = value_ch.valid && ready_d;
	assign slot_free = !out_valid_q || symbol_ch.ready;
	assign chk_sym   = rafmt_pkg::symbol_of(alpha_lo_q, alpha_hi_q,
		rafmt_pkg::SYM_IDX_W'(i_q));
	assign rd_idx    = nd_q - rafmt_pkg::CNT_W'(1);
	assign last_i    = rafmt_pkg::RADIX_W'(i_q) == (radix_q - rafmt_pkg::RADIX_W'(1));
	assign stop      = (div_quot == '0) ||
		(nd_q == rafmt_pkg::CNT_W'(rafmt_pkg::MAX_DIGITS - 1));

	// check: radix in range, symbol i not a sign and unlike all earlier ones
	always_comb begin
		logic dup;
		dup = 1'b0;
		for (int j = 0; j < MAX_RADIX; j++) begin
			if ((rafmt_pkg::SYM_IDX_W'(j) < rafmt_pkg::SYM_IDX_W'(i_q)) &&
				(rafmt_pkg::symbol_of(alpha_lo_q, alpha_hi_q,
					rafmt_pkg::SYM_IDX_W'(j)) == chk_sym)) begin
				dup = 1'b1;
			end
		end
		bad = (radix_q < rafmt_pkg::RADIX_W'(2)) ||
			(radix_q > rafmt_pkg::RADIX_W'(MAX_RADIX)) ||
			(chk_sym == rafmt_pkg::SYM_PLUS) || (chk_sym == rafmt_pkg::SYM_MINUS) || dup;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rafmt_pkg::ST_IDLE: begin
				if (accept) state_d = rafmt_pkg::ST_CHECK;
			end
			rafmt_pkg::ST_CHECK: begin
				if (bad) state_d = rafmt_pkg::ST_IDLE;
				else if (last_i) state_d = rafmt_pkg::ST_DIVIDE;
			end
			rafmt_pkg::ST_DIVIDE: begin
				if (div_done && stop) begin
					state_d = neg_q ? rafmt_pkg::ST_SIGN : rafmt_pkg::ST_EMIT;
				end
			end
			rafmt_pkg::ST_SIGN: begin
				if (slot_free) state_d = rafmt_pkg::ST_EMIT;
			end
			rafmt_pkg::ST_EMIT: begin
				if (slot_free && nd_q == rafmt_pkg::CNT_W'(1)) state_d = rafmt_pkg::ST_IDLE;
			end
			default: state_d = rafmt_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ready_d      = 1'b0;
		div_start    = 1'b0;
		div_dividend = mag_q;
		out_load     = 1'b0;
		sym_d        = rafmt_pkg::symbol_of(alpha_lo_q, alpha_hi_q,
			rafmt_pkg::SYM_IDX_W'(digits_q[rd_idx[rafmt_pkg::PTR_W-1:0]]));
		last_d       = 1'b0;
		unique case (state_q)
			rafmt_pkg::ST_IDLE: ready_d = 1'b1;
			rafmt_pkg::ST_CHECK: div_start = !bad && last_i;
			rafmt_pkg::ST_DIVIDE: begin
				div_dividend = div_quot;
				div_start    = div_done && !stop;
			end
			rafmt_pkg::ST_SIGN: begin
				out_load = slot_free;
				sym_d    = rafmt_pkg::SYM_MINUS;
			end
			rafmt_pkg::ST_EMIT: begin
				out_load = slot_free;
				last_d   = nd_q == rafmt_pkg::CNT_W'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rafmt_pkg::ST_IDLE;
			i_q     <= '0;
			nd_q    <= '0;
			neg_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				rafmt_pkg::ST_IDLE: begin
					if (accept) begin
						i_q   <= '0;
						nd_q  <= '0;
						neg_q <= value_ch.value[rafmt_pkg::DATA_W-1];
					end
				end
				rafmt_pkg::ST_CHECK: i_q <= i_q + DIG_W'(1);
				rafmt_pkg::ST_DIVIDE: begin
					if (div_done) nd_q <= nd_q + rafmt_pkg::CNT_W'(1);
				end
				rafmt_pkg::ST_EMIT: begin
					if (slot_free) nd_q <= nd_q - rafmt_pkg::CNT_W'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= value_ch.value[rafmt_pkg::DATA_W-1] ?
				(rafmt_pkg::DATA_W'(0) - rafmt_pkg::DATA_W'(value_ch.value)) :
				rafmt_pkg::DATA_W'(value_ch.value);
		end
		if (state_q == rafmt_pkg::ST_DIVIDE && div_done) begin
			digits_q[nd_q[rafmt_pkg::PTR_W-1:0]] <= div_rem;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (symbol_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			symbol_q <= sym_d;
			last_q   <= last_d;
		end
	end

	rafmt_div #(
		.MAX_RADIX (MAX_RADIX)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (radix_q),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	assign value_ch.ready   = ready_d;
	assign symbol_ch.valid  = out_valid_q;
	assign symbol_ch.symbol = symbol_q;
	assign symbol_ch.last   = last_q;

	`RAF_ASSERT(a_accept_to_check, clk, arst_n, accept |=> state_q == rafmt_pkg::ST_CHECK, "accepted beat did not start the check")
	`RAF_ASSERT(a_done_in_divide, clk, arst_n, div_done |-> state_q == rafmt_pkg::ST_DIVIDE, "divider finished outside the divide phase")
	`RAF_ASSERT(a_last_ends_item, clk, arst_n, (out_load && last_d) |=> state_q == rafmt_pkg::ST_IDLE, "last character did not end the item")
	`RAF_ASSERT(a_digit_bound, clk, arst_n, nd_q <= rafmt_pkg::CNT_W'(rafmt_pkg::MAX_DIGITS), "digit count overran the store")
endmodule
`default_nettype wire

// File: rtl/core/rafmt_div.sv
// multi-cycle divider of a 32-bit word by the radix, several quotient bits per cycle
`default_nettype none
module rafmt_div #(
	parameter int MAX_RADIX = rafmt_pkg::MAX_RADIX_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [rafmt_pkg::DATA_W-1:0]     dividend,
	input  wire logic [rafmt_pkg::RADIX_W-1:0]    divisor,
	output logic                                  done,
	output logic [rafmt_pkg::DATA_W-1:0]          quotient,
	output logic [$clog2(MAX_RADIX)-1:0]          remainder
);
	localparam int DIG_W  = $clog2(MAX_RADIX);
	localparam int STEPS  = rafmt_pkg::DATA_W / rafmt_pkg::DIV_BITS;
	localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic [rafmt_pkg::DATA_W-1:0] work_q, work_d;
	logic [DIG_W-1:0]             rem_q, rem_d;
	logic [STEP_W-1:0]            cnt_q;
	logic                         busy_q;
	logic                         done_q;

	always_comb begin
		logic [DIG_W:0]                part;
		logic [rafmt_pkg::RADIX_W-1:0] diff;
		logic [DIG_W-1:0]              r;
		logic [rafmt_pkg::DATA_W-1:0]  w;
		r    = rem_q;
		w    = work_q;
		part = '0;
		diff = '0;
		for (int k = 0; k < rafmt_pkg::DIV_BITS; k++) begin
			part = {r, w[rafmt_pkg::DATA_W-1]};
			w    = {w[rafmt_pkg::DATA_W-2:0], 1'b0};
			diff = rafmt_pkg::RADIX_W'(part) - divisor;
			if (rafmt_pkg::RADIX_W'(part) >= divisor) begin
				w[0] = 1'b1;
				r    = diff[DIG_W-1:0];
			end else begin
				r = part[DIG_W-1:0];
			end
		end
		work_d = w;
		rem_d  = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (cnt_q == STEP_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			work_q <= work_d;
			rem_q  <= rem_d;
		end
	end

	assign done      = done_q;
	assign quotient  = work_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

// File: tb/sv/radix_alphabet_int_formatter_tb.sv
// testbench for the radix formatter: random and directed integers checked against a local predictor
`timescale 1ns / 1ps
module radix_alphabet_int_formatter_tb;

	localparam int SETTLE_CYCLES = 300;
	localparam int LONG_HOLD = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 185;
	localparam logic [rafmt_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [rafmt_pkg::SYM_W-1:0] symbol;
		logic                        last;
	} char_beat_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [rafmt_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [rafmt_pkg::ALPHA_W-1:0]   cfg_data;

	rafmt_value_if  value_ch();
	rafmt_symbol_if symbol_ch();

	radix_alphabet_int_formatter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.value_ch  (value_ch),
		.symbol_ch (symbol_ch)
	);

	logic [rafmt_pkg::RADIX_W-1:0] cfg_radix;
	logic [rafmt_pkg::ALPHA_W-1:0] cfg_alpha_lo;
	logic [rafmt_pkg::ALPHA_W-1:0] cfg_alpha_hi;

	logic [rafmt_pkg::DATA_W-1:0] pending_values[$];
	char_beat_t                   expected_chars[$];

	bit tx_idle_en;
	bit rx_idle_en;
	bit tx_offer;
	int tx_wait;
	int rx_wait;
	int hold_req;
	int hold_seen;
	int hold_cnt;
	int quiet_cycles;
	int mismatches;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [rafmt_pkg::SYM_W-1:0] digit_char(input int d);
		logic [2*rafmt_pkg::ALPHA_W-1:0] table_bits;
		table_bits = {cfg_alpha_hi, cfg_alpha_lo} >> (d * rafmt_pkg::SYM_W);
		return table_bits[rafmt_pkg::SYM_W-1:0];
	endfunction

	function automatic bit alphabet_usable(input int r);
		logic [rafmt_pkg::SYM_W-1:0] s;
		if (r < 2 || r > rafmt_pkg::MAX_RADIX_DEF) return 1'b0;
		for (int i = 0; i < r; i++) begin
			s = digit_char(i);
			if (s == rafmt_pkg::SYM_PLUS || s == rafmt_pkg::SYM_MINUS) return 1'b0;
			for (int j = 0; j < i; j++)
				if (digit_char(j) == s) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void format_expected(input logic [rafmt_pkg::DATA_W-1:0] raw);
		int                           r;
		logic [rafmt_pkg::DATA_W-1:0] mag;
		logic [rafmt_pkg::SYM_W-1:0]  digits [rafmt_pkg::MAX_DIGITS];
		int                           nd;
		r = int'(cfg_radix);
		if (!alphabet_usable(r)) return;
		mag = raw[rafmt_pkg::DATA_W-1] ? (32'd0 - raw) : raw;
		nd = 0;
		do begin
			digits[nd] = digit_char(int'(mag % r));
			mag = mag / r;
			nd++;
		end while (mag != 0 && nd < rafmt_pkg::MAX_DIGITS);
		if (raw[rafmt_pkg::DATA_W-1])
			expected_chars.push_back(char_beat_t'{symbol: rafmt_pkg::SYM_MINUS, last: 1'b0});
		for (int i = nd - 1; i >= 0; i--)
			expected_chars.push_back(char_beat_t'{symbol: digits[i], last: (i == 0)});
	endfunction

	function automatic logic [rafmt_pkg::DATA_W-1:0] pick_value();
		logic [rafmt_pkg::DATA_W-1:0] v;
		case ($urandom_range(0, 5))
			0: v = $urandom;
			1: v = $urandom_range(0, 400);
			2: v = 32'd0 - $urandom_range(0, 400);
			3: begin
				case ($urandom_range(0, 3))
					0: v = 32'h7FFF_FFFF;
					1: v = 32'h8000_0000;
					2: v = 32'hFFFF_FFFF;
					default: v = 32'h0;
				endcase
			end
			4: v = $urandom >> $urandom_range(0, 31);
			default: v = 32'd0 - ($urandom >> $urandom_range(0, 31));
		endcase
		return v;
	endfunction

	task automatic pick_setting(input int forced_radix, input bit make_bad,
			output logic [rafmt_pkg::RADIX_W-1:0] r,
			output logic [rafmt_pkg::ALPHA_W-1:0] lo,
			output logic [rafmt_pkg::ALPHA_W-1:0] hi);
		logic [rafmt_pkg::SYM_W-1:0] syms [16];
		bit [255:0]                  taken;
		logic [rafmt_pkg::SYM_W-1:0] s;
		int                          i;
		int                          j;
		taken = '0;
		r = (forced_radix != 0) ? rafmt_pkg::RADIX_W'(forced_radix)
			: rafmt_pkg::RADIX_W'($urandom_range(2, 16));
		for (i = 0; i < 16; i++) begin
			if (i < r) begin
				do s = rafmt_pkg::SYM_W'($urandom);
				while (taken[s] || s == rafmt_pkg::SYM_PLUS || s == rafmt_pkg::SYM_MINUS);
				taken[s] = 1'b1;
			end else begin
				s = rafmt_pkg::SYM_W'($urandom);
			end
			syms[i] = s;
		end
		if (make_bad) begin
			case ($urandom_range(0, 3))
				0: r = $urandom_range(0, 1) ? rafmt_pkg::RADIX_W'($urandom_range(0, 1))
					: rafmt_pkg::RADIX_W'($urandom_range(17, 31));
				1: begin
					i = $urandom_range(1, r - 1);
					j = $urandom_range(0, i - 1);
					syms[i] = syms[j];
				end
				2: syms[$urandom_range(0, r - 1)] = rafmt_pkg::SYM_PLUS;
				default: syms[$urandom_range(0, r - 1)] = rafmt_pkg::SYM_MINUS;
			endcase
		end
		for (i = 0; i < 8; i++) begin
			lo[i*rafmt_pkg::SYM_W +: rafmt_pkg::SYM_W] = syms[i];
			hi[i*rafmt_pkg::SYM_W +: rafmt_pkg::SYM_W] = syms[i+8];
		end
	endtask

	task automatic write_reg(input logic [rafmt_pkg::CFG_IDX_W-1:0] idx,
			input logic [rafmt_pkg::ALPHA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			rafmt_pkg::REG_RADIX: cfg_radix = data[rafmt_pkg::RADIX_W-1:0];
			rafmt_pkg::REG_ALPHA_LO: cfg_alpha_lo = data;
			rafmt_pkg::REG_ALPHA_HI: cfg_alpha_hi = data;
			default: ;
		endcase
	endtask

	task automatic apply_setting(input logic [rafmt_pkg::RADIX_W-1:0] r,
			input logic [rafmt_pkg::ALPHA_W-1:0] lo,
			input logic [rafmt_pkg::ALPHA_W-1:0] hi);
		write_reg(rafmt_pkg::REG_RADIX, {27'($urandom), 32'($urandom), r});
		write_reg(rafmt_pkg::REG_ALPHA_LO, lo);
		write_reg(rafmt_pkg::REG_ALPHA_HI, hi);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (pending_values.size() != 0 || value_ch.valid || expected_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// value driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_ch.valid <= 1'b0;
			value_ch.value <= '0;
			tx_offer = 1'b0;
			tx_wait = 0;
		end else begin
			tx_offer = value_ch.valid;
			if (value_ch.valid && value_ch.ready) begin
				format_expected(value_ch.value);
				tx_offer = 1'b0;
				tx_wait = tx_idle_en ? $urandom_range(0, 19) : 0;
			end else if (!tx_offer && tx_wait > 0) begin
				tx_wait = tx_wait - 1;
			end
			if (!tx_offer && tx_wait == 0 && pending_values.size() != 0) begin
				value_ch.value <= pending_values.pop_front();
				tx_offer = 1'b1;
			end
			value_ch.valid <= tx_offer;
		end
	end

	// symbol monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_ch.ready <= 1'b0;
			rx_wait = 0;
			hold_cnt = 0;
			hold_seen = 0;
			mismatches = 0;
		end else begin
			if (symbol_ch.valid && symbol_ch.ready) begin
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected beat expected none actual symbol %0h last %0b",
						$time, symbol_ch.symbol, symbol_ch.last);
					mismatches++;
				end else begin
					if (symbol_ch.symbol !== expected_chars[0].symbol) begin
						$display("%0t: symbol expected %0h actual %0h", $time,
							expected_chars[0].symbol, symbol_ch.symbol);
						mismatches++;
					end
					if (symbol_ch.last !== expected_chars[0].last) begin
						$display("%0t: last expected %0b actual %0b", $time,
							expected_chars[0].last, symbol_ch.last);
						mismatches++;
					end
					void'(expected_chars.pop_front());
				end
				rx_wait = rx_idle_en ? $urandom_range(0, 19) : 0;
			end else if (rx_wait > 0) begin
				rx_wait = rx_wait - 1;
			end
			if (hold_cnt > 0) begin
				hold_cnt = hold_cnt - 1;
				symbol_ch.ready <= 1'b0;
			end else if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_cnt = LONG_HOLD;
				symbol_ch.ready <= 1'b0;
			end else begin
				symbol_ch.ready <= (rx_wait == 0);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((value_ch.valid && value_ch.ready) || (symbol_ch.valid && symbol_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("radix_alphabet_int_formatter verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [rafmt_pkg::RADIX_W-1:0] r;
		logic [rafmt_pkg::ALPHA_W-1:0] lo;
		logic [rafmt_pkg::ALPHA_W-1:0] hi;
		bit                            bad;
		int                            n;
		int                            phase;
		int                            random_items;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cfg_radix = rafmt_pkg::RADIX_RESET;
		cfg_alpha_lo = rafmt_pkg::ALPHA_LO_RESET;
		cfg_alpha_hi = rafmt_pkg::ALPHA_HI_RESET;
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		hold_req = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset alphabet, decimal
		pending_values.push_back(32'h0000_0000);
		pending_values.push_back(32'hFFFF_FFFF);
		pending_values.push_back(32'h7FFF_FFFF);
		pending_values.push_back(32'h8000_0000);
		pending_values.push_back(32'd9);
		pending_values.push_back(-32'sd10);
		drain();

		apply_setting(5'd2, rafmt_pkg::ALPHA_LO_RESET, rafmt_pkg::ALPHA_HI_RESET);
		pending_values.push_back(32'h8000_0000);
		pending_values.push_back(32'h7FFF_FFFF);
		drain();

		apply_setting(5'd16, rafmt_pkg::ALPHA_LO_RESET, rafmt_pkg::ALPHA_HI_RESET);
		pending_values.push_back(32'h8000_0000);
		pending_values.push_back(32'h7FED_CBA9);
		drain();

		// radix out of range
		apply_setting(5'd0, rafmt_pkg::ALPHA_LO_RESET, rafmt_pkg::ALPHA_HI_RESET);
		pending_values.push_back(32'd77);
		drain();
		apply_setting(5'd1, rafmt_pkg::ALPHA_LO_RESET, rafmt_pkg::ALPHA_HI_RESET);
		pending_values.push_back(32'd5);
		drain();
		apply_setting(5'd17, rafmt_pkg::ALPHA_LO_RESET, rafmt_pkg::ALPHA_HI_RESET);
		pending_values.push_back(32'd123);
		drain();
		apply_setting(5'd31, rafmt_pkg::ALPHA_LO_RESET, rafmt_pkg::ALPHA_HI_RESET);
		pending_values.push_back(-32'sd1000);
		drain();

		// plus, minus and far duplicate among used symbols
		apply_setting(5'd10, 64'h3736_2B34_3332_3130, rafmt_pkg::ALPHA_HI_RESET);
		pending_values.push_back(32'd42);
		drain();
		apply_setting(5'd10, rafmt_pkg::ALPHA_LO_RESET, 64'h4645_4443_4241_2D38);
		pending_values.push_back(32'd42);
		drain();
		apply_setting(5'd16, rafmt_pkg::ALPHA_LO_RESET, 64'h3045_4443_4241_3938);
		pending_values.push_back(32'd255);
		drain();

		// zero byte as digit zero
		apply_setting(5'd3, 64'h3736_3534_3362_6100, rafmt_pkg::ALPHA_HI_RESET);
		pending_values.push_back(32'd0);
		pending_values.push_back(-32'sd5);
		drain();

		// unused bytes hold signs and repeats, plus a write past the register list
		apply_setting(5'd4, 64'h2B2D_3030_3332_3130, 64'h2D2D_2D2D_2D2D_2D2D);
		write_reg(REG_UNUSED, {32'($urandom), 32'($urandom)});
		@(posedge clk);
		cfg_we <= 1'b0;
		pending_values.push_back(32'd100);
		drain();

		random_items = 0;
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			bad = (phase > 1) && ($urandom_range(0, 4) == 0);
			pick_setting((phase == 0) ? 2 : (phase == 1) ? 16 : 0, bad, r, lo, hi);
			apply_setting(r, lo, hi);
			tx_idle_en <= ($urandom_range(0, 3) != 0);
			rx_idle_en <= ($urandom_range(0, 3) != 0);
			n = bad ? 4 : $urandom_range(10, 22);
			repeat (n) pending_values.push_back(pick_value());
			random_items += n;
			if (phase == 2 || $urandom_range(0, 5) == 0) hold_req <= hold_req + 1;
			drain();
			phase++;
		end

		if (mismatches == 0 && expected_chars.size() == 0) begin
			$display("radix_alphabet_int_formatter verification clean");
		end else begin
			$display("radix_alphabet_int_formatter verification failed");
		end
		$finish;
	end
endmodule
